[rtl/keyword_token_scanner_macros.svh]
// keyword_token_scanner_macros.svh
// assertion macros shared by the scanner's checker; no other dependencies
`ifndef KEYWORD_TOKEN_SCANNER_MACROS_SVH
`define KEYWORD_TOKEN_SCANNER_MACROS_SVH

// property checked on every rising edge outside reset
`define KTS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyword_token_scanner check failed");

// property checked on every rising edge, reset included
`define KTS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("keyword_token_scanner check failed during reset");

`endif

[rtl/kts_pkg.sv]
// kts_pkg.sv
// constants, vocabulary table and byte helpers for the keyword token scanner
// no dependencies
package kts_pkg;

    localparam int VOCAB_SIZE   = 26;
    localparam int ENTRY_COLS   = 9;   // longest vocabulary entry
    localparam int LONGEST_WORD = 9;   // words longer than this are unknown
    localparam int LEN_W        = 4;   // saturating length count width
    localparam int ID_W         = 5;
    localparam int BYTE_W       = 8;

    localparam logic [LEN_W-1:0] LENGTH_MAX = '1;
    localparam logic [ID_W-1:0]  ID_UNKNOWN = '0;

    // separator characters
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3f;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    localparam logic [BYTE_W-1:0] NUL = 8'h00;

    // vocabulary, token id is row index plus one
    localparam logic [BYTE_W-1:0] VOCAB_CHARS [VOCAB_SIZE][ENTRY_COLS] = '{
        '{"h", "e", "l", "l", "o", NUL, NUL, NUL, NUL},
        '{"h", "i", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
        '{8'h76, 8'h6f, 8'h72, 8'h74, 8'h65, 8'h78, NUL, NUL, NUL},
        '{"p", "h", "y", "s", "i", "c", "s", NUL, NUL},
        '{"m", "a", "t", "h", NUL, NUL, NUL, NUL, NUL},
        '{"a", "i", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
        '{"m", "e", "m", "o", "r", "y", NUL, NUL, NUL},
        '{"e", "n", "e", "r", "g", "y", NUL, NUL, NUL},
        '{"c", "o", "m", "p", "u", "t", "e", NUL, NUL},
        '{"t", "e", "l", "l", NUL, NUL, NUL, NUL, NUL},
        '{"m", "e", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
        '{"j", "o", "k", "e", NUL, NUL, NUL, NUL, NUL},
        '{"n", "a", "m", "e", NUL, NUL, NUL, NUL, NUL},
        '{"w", "h", "a", "t", NUL, NUL, NUL, NUL, NUL},
        '{"i", "s", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
        '{"y", "o", "u", "r", NUL, NUL, NUL, NUL, NUL},
        '{"g", "r", "a", "v", "i", "t", "y", NUL, NUL},
        '{"f", "o", "r", "c", "e", NUL, NUL, NUL, NUL},
        '{"n", "e", "u", "r", "a", "l", NUL, NUL, NUL},
        '{"n", "e", "t", "w", "o", "r", "k", NUL, NUL},
        '{"l", "e", "a", "r", "n", "i", "n", "g", NUL},
        '{"p", "o", "w", "e", "r", NUL, NUL, NUL, NUL},
        '{"b", "a", "t", "t", "e", "r", "y", NUL, NUL},
        '{"a", "l", "g", "o", "r", "i", "t", "h", "m"},
        '{"d", "a", "t", "a", NUL, NUL, NUL, NUL, NUL},
        '{"a", "b", "o", "u", "t", NUL, NUL, NUL, NUL}
    };

    // length of each vocabulary entry
    localparam logic [LEN_W-1:0] ENTRY_LEN [VOCAB_SIZE] = '{
        4'd5, 4'd2, 4'd6, 4'd7, 4'd4, 4'd2, 4'd6, 4'd6, 4'd7, 4'd4,
        4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd4, 4'd7, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd5, 4'd7, 4'd9, 4'd4, 4'd5
    };

    localparam logic [LEN_W-1:0] LONGEST_LEN = LEN_W'(LONGEST_WORD);

    // fold ascii capitals to lower case
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

    // word break characters
    function automatic logic is_separator(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB) ||
               (c == CH_DOT) || (c == CH_COMMA) || (c == CH_QUEST) || (c == CH_BANG);
    endfunction

endpackage

[rtl/keyword_token_scanner.sv]
// keyword_token_scanner.sv
// top level: byte register, word matcher, token output register
// depends on kts_pkg
//
// Keyword token scanner. Takes one text byte per beat on the s_ side and
// emits one token beat on the m_ side for every non-empty word, ended by a
// separator (space, tab, newline, return, period, comma, question or
// exclamation mark) or by the text's final byte (s_tlast). The token is the
// 1-based index of the word in the 26-word vocabulary, or 0 for an unknown
// word; m_tlast marks a token emitted on the text's final byte. Capitals are
// folded to lower case. A byte waits in the input register and
// is matched against all vocabulary entries in parallel on its way to the
// output register, which holds the token beat; the block takes one byte
// per cycle while the output is not stalled.
module keyword_token_scanner
    import kts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // final_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [4:0] token_id, [7:5] zero
    output logic        m_tlast     // text_done
);

    // input register
    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;

    // matcher state
    logic [VOCAB_SIZE-1:0] cand_reg, cand_next;
    logic [LEN_W-1:0]      len_reg, len_next;

    // output register
    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_done_reg;

    logic                 advance;
    logic [BYTE_W-1:0]    ch;
    logic                 sep;
    logic                 word_end;
    logic                 emit;
    logic [VOCAB_SIZE-1:0] cand_upd;
    logic [LEN_W-1:0]      len_upd;
    logic [ID_W-1:0]       id_next;

    // byte moves on when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // match the registered byte against every vocabulary entry
    always_comb begin
        ch       = fold_case(in_byte_reg);
        sep      = is_separator(ch);
        cand_upd = cand_reg;
        len_upd  = len_reg;
        if (!sep) begin
            for (int w = 0; w < VOCAB_SIZE; w++) begin
                if (!((len_reg < ENTRY_LEN[w]) && (VOCAB_CHARS[w][len_reg] == ch))) begin
                    cand_upd[w] = 1'b0;
                end
            end
            if (len_reg != LENGTH_MAX) begin
                len_upd = len_reg + 1'b1;
            end
        end

        // at most one entry of matching length survives
        id_next = ID_UNKNOWN;
        if (len_upd <= LONGEST_LEN) begin
            for (int w = 0; w < VOCAB_SIZE; w++) begin
                if (cand_upd[w] && (ENTRY_LEN[w] == len_upd)) begin
                    id_next = id_next | ID_W'(w + 1);
                end
            end
        end

        word_end = sep || in_last_reg;
        emit     = word_end && (len_upd != '0);

        if (word_end) begin
            cand_next = '1;
            len_next  = '0;
        end else begin
            cand_next = cand_upd;
            len_next  = len_upd;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // matcher state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '1;
            len_reg  <= '0;
        end else if (advance) begin
            cand_reg <= cand_next;
            len_reg  <= len_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            out_id_reg   <= id_next;
            out_done_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - ID_W){1'b0}}, out_id_reg};
    assign m_tlast  = out_done_reg;

endmodule

[rtl/kts_checker.sv]
// kts_checker.sv
// port-level checks for the keyword token scanner, bound to the top level
// depends on keyword_token_scanner_macros.svh
`include "keyword_token_scanner_macros.svh"

module kts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled token beat holds
    `KTS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // token ids stay inside the vocabulary, upper bits zero
    `KTS_ASSERT(a_id_range, aclk, aresetn, m_tvalid |-> (m_tdata[4:0] <= 5'd26) && (m_tdata[7:5] == 3'd0))

    // with the output empty the input side is never stalled
    `KTS_ASSERT(a_in_ready, aclk, aresetn, !m_tvalid && $past(!m_tvalid) |-> s_tready)

    // reset empties the output
    `KTS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind keyword_token_scanner kts_checker u_kts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/keyword_token_scanner_test.sv]
// keyword_token_scanner_test.sv
// self-checking testbench: text byte stream in, token beats out, checked
// against an in-bench word matcher; depends on keyword_token_scanner only
module keyword_token_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;   // cycles without any beat before giving up
    localparam int RANDOM_BYTES = 1700;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_BURSTY} pace_t;

    typedef struct packed {
        logic [4:0] token_id;
        logic       text_done;
    } token_beat_t;

    // word matcher: mirrors the scanner state and queues expected token beats
    class token_predictor;
        localparam int VOCAB_WORDS = 26;
        localparam int LONGEST     = 9;

        string       vocab [VOCAB_WORDS];
        logic [25:0] live_words;
        logic [3:0]  word_len;
        token_beat_t expected_tokens [$];

        function new();
            string tail;
            tail  = "rtex";
            vocab = '{"hello", "hi", "", "physics", "math", "ai", "memory",
                      "energy", "compute", "tell", "me", "joke", "name", "what",
                      "is", "your", "gravity", "force", "neural", "network",
                      "learning", "power", "battery", "algorithm", "data", "about"};
            vocab[2] = {"vo", tail};
            clear_word();
        endfunction

        function void clear_word();
            live_words = '1;
            word_len   = '0;
        endfunction

        // space, newline, return, tab, period, comma, question and exclamation mark
        static function bit is_break(logic [7:0] c);
            return (c == 8'h20) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09) ||
                   (c == 8'h2e) || (c == 8'h2c) || (c == 8'h3f) || (c == 8'h21);
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        // one accepted text beat
        function void note_byte(logic [7:0] raw, logic last);
            logic [7:0]  c;
            logic [4:0]  id;
            token_beat_t beat;
            int          len;
            int          w;
            c = raw;
            if (c >= 8'h41 && c <= 8'h5a) begin
                c = c + 8'h20;
            end
            // narrow the candidate set with this character
            if (!is_break(c)) begin
                for (w = 0; w < VOCAB_WORDS; w++) begin
                    len = vocab[w].len();
                    if (!(int'(word_len) < len && 8'(vocab[w][word_len]) == c)) begin
                        live_words[w] = 1'b0;
                    end
                end
                if (word_len != 4'hf) begin
                    word_len = word_len + 4'd1;
                end
            end
            // word end: lowest surviving entry of exactly this length wins
            if ((is_break(c) || last) && word_len != 0) begin
                id = '0;
                if (word_len <= LONGEST) begin
                    for (w = VOCAB_WORDS - 1; w >= 0; w--) begin
                        if (live_words[w] && vocab[w].len() == int'(word_len)) begin
                            id = 5'(w + 1);
                        end
                    end
                end
                beat.token_id  = id;
                beat.text_done = last;
                expected_tokens = {expected_tokens, beat};
                clear_word();
            end
            if (last) begin
                clear_word();
            end
        endfunction

        // one accepted token beat; returns 1 on mismatch with the reason in why
        function bit check_token(logic [7:0] data, logic done, output string why);
            token_beat_t want;
            bit          bad;
            why = "";
            if (expected_tokens.size() == 0) begin
                why = $sformatf("token beat id=%0d done=%0b with nothing expected",
                                data[4:0], done);
                return 1'b1;
            end
            want = expected_tokens.pop_front();
            bad  = 1'b0;
            if (data[4:0] !== want.token_id) begin
                why = {why, $sformatf(" token_id %0d want %0d;", data[4:0], want.token_id)};
                bad = 1'b1;
            end
            if (data[7:5] !== 3'b000) begin
                why = {why, $sformatf(" pad bits %b want 000;", data[7:5])};
                bad = 1'b1;
            end
            if (done !== want.text_done) begin
                why = {why, $sformatf(" text_done %b want %b;", done, want.text_done)};
                bad = 1'b1;
            end
            return bad;
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    token_predictor scanner_model;
    logic [7:0]     text_q [$];
    pace_t          sender_pace = PACE_STEADY;
    int             bytes_sent = 0;
    int             mismatch_count = 0;
    int             idle_cycles = 0;

    keyword_token_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d tokens outstanding",
                         IDLE_LIMIT, scanner_model.pending());
                $display("** keyword_token_scanner: FAILED **");
                $finish;
            end
        end
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] token mismatch:%s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int draw_wait(pace_t pace);
        case (pace)
            PACE_STEADY: begin
                return 0;
            end
            PACE_RANDOM: begin
                return $urandom_range(0, 17);
            end
            default: begin
                return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
            end
        endcase
    endfunction

    // one text beat, held until accepted
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = draw_wait(sender_pace);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        scanner_model.note_byte(b, last);
        bytes_sent++;
    endtask

    // send the queued text, marking its last byte as final when asked
    task automatic send_text(bit end_text);
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], end_text && (i == text_q.size() - 1));
        end
        text_q.delete();
    endtask

    // hold the sender until every expected token has come out
    task automatic hold_for_tokens();
        s_tvalid <= 1'b0;
        while (scanner_model.pending() != 0) @(posedge aclk);
    endtask

    // token side: random stalls, every beat checked
    task automatic consume_tokens();
        pace_t pace;
        int    stall;
        string why;
        pace = PACE_RANDOM;
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                pace = pace_t'($urandom_range(0, 2));
            end
            stall = draw_wait(pace);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (scanner_model.check_token(m_tdata, m_tlast, why)) begin
                report_mismatch(why);
            end
        end
    endtask

    function automatic logic [7:0] maybe_upper(logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 3) == 0) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // any byte that is not a word break, letters favored
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1) begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            do c = 8'($urandom_range(0, 255)); while (token_predictor::is_break(c));
        end
        return maybe_upper(c);
    endfunction

    function automatic logic [7:0] break_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (!token_predictor::is_break(c));
        return c;
    endfunction

    // append one byte to the pending text
    task automatic add_byte(logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic queue_string(string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            add_byte(8'(s[i]));
        end
    endtask

    // one word: vocabulary hit, prefix, extension, typo or junk
    task automatic queue_word();
        int    kind;
        int    w;
        int    len;
        int    i;
        int    cut;
        string entry;
        kind  = $urandom_range(0, 99);
        w     = $urandom_range(0, 25);
        entry = scanner_model.vocab[w];
        len   = entry.len();
        if (kind < 60) begin
            for (i = 0; i < len; i++) add_byte(maybe_upper(8'(entry[i])));
        end else if (kind < 70) begin
            cut = $urandom_range(1, len - 1);
            for (i = 0; i < cut; i++) add_byte(maybe_upper(8'(entry[i])));
        end else if (kind < 80) begin
            for (i = 0; i < len; i++) add_byte(maybe_upper(8'(entry[i])));
            cut = $urandom_range(1, 3);
            for (i = 0; i < cut; i++) add_byte(word_char());
        end else if (kind < 88) begin
            cut = $urandom_range(0, len - 1);
            for (i = 0; i < len; i++) begin
                add_byte(i == cut ? word_char() : maybe_upper(8'(entry[i])));
            end
        end else begin
            // junk, now and then long enough to saturate the length count
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            for (i = 0; i < len; i++) add_byte(word_char());
        end
    endtask

    // a well-formed text of words and breaks, or raw noise
    task automatic queue_text();
        int n_words;
        int n_breaks;
        int i;
        int j;
        if ($urandom_range(0, 9) == 0) begin
            n_words = $urandom_range(1, 12);
            for (i = 0; i < n_words; i++) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        n_words = $urandom_range(1, 8);
        for (i = 0; i < n_words; i++) begin
            queue_word();
            if (i < n_words - 1) begin
                n_breaks = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
            end else begin
                n_breaks = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
            end
            for (j = 0; j < n_breaks; j++) add_byte(break_char());
        end
    endtask

    initial begin
        scanner_model = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            consume_tokens();
        join_none

        // directed: case folding, breaks, control and high bytes, final byte cases
        queue_string("HeLLo\tME\r\n.,?");
        add_byte(8'h00);
        add_byte(8'hff);
        send_text(1);
        queue_string("ai ");
        send_text(1);
        queue_string("!");
        send_text(1);
        queue_string("WHAT");
        send_text(1);
        hold_for_tokens();

        // random texts with changing sender pace
        while (bytes_sent < RANDOM_BYTES) begin
            sender_pace = pace_t'($urandom_range(0, 2));
            queue_text();
            send_text($urandom_range(0, 4) != 0);
            if (bytes_sent > RANDOM_BYTES / 2 && $urandom_range(0, 19) == 0) begin
                hold_for_tokens();
            end
        end
        queue_string(".");
        send_text(1);
        s_tvalid <= 1'b0;

        // drain and let any stray beat show up
        while (scanner_model.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("** keyword_token_scanner: PASSED **");
        end else begin
            $display("** keyword_token_scanner: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/kts_pkg.sv
rtl/keyword_token_scanner.sv
rtl/kts_checker.sv
tb/keyword_token_scanner_test.sv
